// ===== hw/rtl/wfg_pkg.sv =====
// Shared types and constants for the wait-for graph deadlock detector.
// Used by wfg_front, wfg_back and the top level; depends on nothing.
package wfg_pkg;

  // Number of tracked nodes and derived widths
  localparam int NODES      = 8;
  localparam int NODE_W     = $clog2(NODES);
  localparam int PARTY_W    = 4;
  localparam int WAITER_W   = 3;
  localparam int IN_MASK_W  = 8;
  localparam int GNODE_W    = 3;

  // Stream payload widths
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  // Front-to-back request queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Request opcodes (tuser on the slave side)
  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_RELEASE  = 1'b1;

  // Message kinds (tuser on the master side)
  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_GRANT = 2'd1,
    KIND_ABORT = 2'd2
  } kind_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic               is_release; // 1: release, 0: register a wait
    logic               in_range;   // node index below NODES
    logic [NODE_W-1:0]  node;       // waiter (register) or releaser (release)
    logic [PARTY_W-1:0] party;      // sender field as received
    logic [NODES-1:0]   mask;       // wait mask trimmed to NODES bits
  } cmd_t;

endpackage

// ===== hw/rtl/wait_for_graph_deadlock_detector.sv =====
// Wait-for graph deadlock detector: a register request ORs a wait mask into the
// waiter's entry and records its lock holder, then checks for a cycle reachable
// from the waiter; on a cycle it sends one abort (tlast set) to the waiter and
// clears that mask, otherwise it sends nothing. A release request clears the
// releaser's bit in every mask, sends a grant to the holder of each mask that
// became empty, in node order, then a commit acknowledgement (tlast set). A
// register request loads the graph, makes NODES closure passes of the
// reachability unit and then checks, waiting while the result stream stalls
// an abort; a release scans the nodes in order, waiting while the result
// stream stalls. A two-entry request queue lets the input keep accepting
// while the back end works. The graph is cleared by reset.
// Depends on wfg_pkg, wfg_front and wfg_back.
module wait_for_graph_deadlock_detector (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [wfg_pkg::IN_DATA_W-1:0] s_tdata,   // sender[3:0], waiter[6:4], wait_mask[14:7]
  input  logic                          s_tuser,   // op
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [wfg_pkg::OUT_DATA_W-1:0] m_tdata,  // dest[3:0], granted_node[6:4]
  output logic [1:0]                    m_tuser,   // kind
  output logic                          m_tlast    // last
);

  logic          q_valid;
  logic          q_ready;
  wfg_pkg::cmd_t q_cmd;

  // Accept and queue requests
  wfg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_ready  (q_ready)
  );

  // Execute requests and send results
  wfg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_ready  (q_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== hw/rtl/wfg_front.sv =====
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on wfg_pkg.
module wfg_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [wfg_pkg::IN_DATA_W-1:0] s_tdata,  // sender[3:0], waiter[6:4], wait_mask[14:7]
  input  logic                         s_tuser,   // op
  output logic                         q_valid,
  output wfg_pkg::cmd_t                q_cmd,
  input  logic                         q_ready
);

  logic [wfg_pkg::PARTY_W-1:0]        sender;
  logic [wfg_pkg::WAITER_W-1:0]       waiter;
  logic [wfg_pkg::IN_MASK_W-1:0]      wait_mask;
  logic [wfg_pkg::NODES+wfg_pkg::IN_MASK_W-1:0] mask_ext;
  wfg_pkg::cmd_t                      cmd;
  logic                               push;
  logic                               pop;

  wfg_pkg::cmd_t                      q_mem [wfg_pkg::QUEUE_DEPTH];
  logic [wfg_pkg::QPTR_W-1:0]         wr_ptr;
  logic [wfg_pkg::QPTR_W-1:0]         rd_ptr;
  logic [wfg_pkg::QCNT_W-1:0]         count;

  // Unpack and classify the incoming request
  always_comb begin
    sender    = s_tdata[3:0];
    waiter    = s_tdata[6:4];
    wait_mask = s_tdata[14:7];
    mask_ext  = {{wfg_pkg::NODES{1'b0}}, wait_mask};
    cmd.is_release = (s_tuser == wfg_pkg::OP_RELEASE);
    cmd.party      = sender;
    cmd.mask       = mask_ext[wfg_pkg::NODES-1:0];
    if (cmd.is_release) begin
      cmd.node     = wfg_pkg::NODE_W'(sender);
      cmd.in_range = (int'(sender) < wfg_pkg::NODES);
    end else begin
      cmd.node     = wfg_pkg::NODE_W'(waiter);
      cmd.in_range = (int'(waiter) < wfg_pkg::NODES);
    end
  end

  // Accept while the queue has room; drop a register request whose waiter is out of range
  assign s_tready = (count != wfg_pkg::QCNT_W'(wfg_pkg::QUEUE_DEPTH));
  assign push     = s_tvalid && s_tready && (cmd.is_release || cmd.in_range);
  assign q_valid  = (count != '0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = q_mem[rd_ptr];

  // Hold queued requests
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cmd;
    end
  end

  // Advance queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == wfg_pkg::QPTR_W'(wfg_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == wfg_pkg::QPTR_W'(wfg_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/wfg_back.sv =====
// Back end: holds the wait-for graph, runs cycle checks and release scans,
// and drives the result register. Depends on wfg_pkg.
module wfg_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  wfg_pkg::cmd_t                 q_cmd,
  output logic                          q_ready,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [wfg_pkg::OUT_DATA_W-1:0] m_tdata,  // dest[3:0], granted_node[6:4]
  output logic [1:0]                    m_tuser,   // kind
  output logic                          m_tlast    // last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLOSE,
    S_CHECK,
    S_GRANT,
    S_ACK
  } state_t;

  state_t                         state;
  logic [wfg_pkg::NODES-1:0]      wait_masks  [wfg_pkg::NODES];
  logic [wfg_pkg::PARTY_W-1:0]    lock_holder [wfg_pkg::NODES];
  logic [wfg_pkg::NODES-1:0]      reach       [wfg_pkg::NODES];
  logic [wfg_pkg::NODE_W-1:0]     node_q;
  logic [wfg_pkg::PARTY_W-1:0]    party_q;
  logic                           rel_ok;
  logic [wfg_pkg::NODES-1:0]      empties;
  logic [wfg_pkg::NODE_W-1:0]     idx;

  // Result register
  wfg_pkg::kind_t                 out_kind;
  logic [wfg_pkg::PARTY_W-1:0]    out_dest;
  logic [wfg_pkg::GNODE_W-1:0]    out_node;
  logic                           out_last;
  logic                           out_valid;
  logic                           out_free;
  logic                           out_load;

  // Combinational helpers
  logic [wfg_pkg::NODES-1:0]      masks_upd   [wfg_pkg::NODES];
  logic [wfg_pkg::NODES-1:0]      masks_rel   [wfg_pkg::NODES];
  logic [wfg_pkg::NODES-1:0]      reach_step  [wfg_pkg::NODES];
  logic [wfg_pkg::NODES-1:0]      empties_new;
  logic [wfg_pkg::NODES-1:0]      keep;
  logic [wfg_pkg::NODES-1:0]      seen;
  logic [wfg_pkg::NODES-1:0]      diag;
  logic                           cyc;
  logic                           idx_last;
  logic                           rel_col_set;
  logic                           reach_covers;

  assign out_free = !out_valid || m_tready;
  assign q_ready  = (state == S_IDLE);
  assign idx_last = (idx == wfg_pkg::NODE_W'(wfg_pkg::NODES - 1));

  // Load a new result whenever a state emits one and the register is free
  assign out_load = out_free && (((state == S_CHECK) && cyc) ||
                                 ((state == S_GRANT) && empties[idx]) ||
                                 (state == S_ACK));

  // Build the register update, the release update and one closure pass
  always_comb begin
    if (q_cmd.in_range) begin
      keep = ~({{(wfg_pkg::NODES-1){1'b0}}, 1'b1} << q_cmd.node);
    end else begin
      keep = '1;
    end
    for (int i = 0; i < wfg_pkg::NODES; i++) begin
      masks_upd[i] = wait_masks[i];
      if (wfg_pkg::NODE_W'(i) == q_cmd.node) begin
        masks_upd[i] = wait_masks[i] | q_cmd.mask;
      end
      masks_rel[i]   = wait_masks[i] & keep;
      empties_new[i] = q_cmd.in_range && (wait_masks[i] != '0) && (masks_rel[i] == '0);
      reach_step[i]  = reach[i];
      for (int j = 0; j < wfg_pkg::NODES; j++) begin
        if (reach[i][j]) begin
          reach_step[i] = reach_step[i] | wait_masks[j];
        end
      end
      diag[i] = reach[i][i];
    end
  end

  // Flag a cycle among the nodes reachable from the waiter
  always_comb begin
    seen = reach[node_q];
    seen[node_q] = 1'b1;
    cyc = |(seen & diag);
  end

  // Sequence requests, update the graph and load results
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < wfg_pkg::NODES; i++) begin
        wait_masks[i]  <= '0;
        lock_holder[i] <= '0;
      end
    end else begin
      // Hold the result until the receiver takes it
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            node_q  <= q_cmd.node;
            party_q <= q_cmd.party;
            idx     <= '0;
            if (q_cmd.is_release) begin
              rel_ok  <= q_cmd.in_range;
              empties <= empties_new;
              for (int i = 0; i < wfg_pkg::NODES; i++) begin
                wait_masks[i] <= masks_rel[i];
              end
              state <= S_GRANT;
            end else begin
              lock_holder[q_cmd.node] <= q_cmd.party;
              for (int i = 0; i < wfg_pkg::NODES; i++) begin
                wait_masks[i] <= masks_upd[i];
                reach[i]      <= masks_upd[i];
              end
              state <= S_CLOSE;
            end
          end
        end
        S_CLOSE: begin
          for (int i = 0; i < wfg_pkg::NODES; i++) begin
            reach[i] <= reach_step[i];
          end
          idx <= idx + 1'b1;
          if (idx_last) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!cyc) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_kind           <= wfg_pkg::KIND_ABORT;
            out_dest           <= wfg_pkg::PARTY_W'(node_q);
            out_node           <= '0;
            out_last           <= 1'b1;
            wait_masks[node_q] <= '0;
            state              <= S_IDLE;
          end
        end
        S_GRANT: begin
          if (!empties[idx] || out_free) begin
            if (empties[idx]) begin
              out_kind  <= wfg_pkg::KIND_GRANT;
              out_dest  <= lock_holder[idx];
              out_node  <= wfg_pkg::GNODE_W'(idx);
              out_last  <= 1'b0;
            end
            idx <= idx + 1'b1;
            if (idx_last) begin
              state <= S_ACK;
            end
          end
        end
        S_ACK: begin
          if (out_free) begin
            out_kind  <= wfg_pkg::KIND_ACK;
            out_dest  <= party_q;
            out_node  <= '0;
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = wfg_pkg::OUT_DATA_W'({out_node, out_dest});
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

  // Checks on graph bookkeeping
  always_comb begin
    rel_col_set  = 1'b0;
    reach_covers = 1'b1;
    for (int i = 0; i < wfg_pkg::NODES; i++) begin
      rel_col_set  = rel_col_set | wait_masks[i][node_q];
      reach_covers = reach_covers && ((wait_masks[i] & ~reach[i]) == '0);
    end
  end

  a_abort_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && cyc && out_free) |=> (wait_masks[node_q] == '0))
    else $error("abort did not clear the waiter mask");

  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACK && rel_ok) |-> !rel_col_set)
    else $error("releaser bit still set in a wait mask");

  a_grant_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_GRANT && empties[idx] && out_free)
      |=> (m_tvalid && m_tuser == wfg_pkg::KIND_GRANT && !m_tlast))
    else $error("grant not loaded into the result register");

  a_closure_covers: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> reach_covers)
    else $error("reachability set misses a direct wait edge");

endmodule
